[design/fps_pkg.sv]
// Shared constants and the pipeline slot type for the fraction product scaler.
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

  // Number of multiplier bits consumed, top bit first; one cell per bit.
  localparam int SCALE_BITS = 32;

  localparam int NUM_W   = 64;
  localparam int SCALE_W = 32;
  localparam int QUO_W   = 32;

  // Running quotient width: one bit per step.
  localparam int QACC_W = SCALE_BITS;

  typedef struct packed {
    logic                  err;
    logic [NUM_W-1:0]      rem;
    logic [NUM_W-1:0]      div;
    logic [SCALE_W-1:0]    scale;
    logic [QACC_W-1:0]     q;
    logic [NUM_W-1:0]      r;
  } fps_slot_t;

endpackage

`default_nettype wire

[design/fps_cell.sv]
// One step cell: double with reduction, then conditional add with reduction.
`timescale 1ns / 1ps
`default_nettype none

module fps_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              valid_i,
  input  wire logic              mbit_i,
  input  wire fps_pkg::fps_slot_t slot_i,
  output logic                   valid_o,
  output fps_pkg::fps_slot_t     slot_o
);

  fps_pkg::fps_slot_t mid_r, mid_nxt;
  logic               mid_valid_r;
  logic               mid_mbit_r;
  fps_pkg::fps_slot_t out_r, out_nxt;
  logic               out_valid_r;

  logic [fps_pkg::NUM_W+1:0] dbl_diff;
  logic [fps_pkg::NUM_W:0]   add_sum;
  logic [fps_pkg::NUM_W+1:0] add_diff;

  // Doubling half: 2r - div decides the reduction.
  always_comb begin
    mid_nxt  = slot_i;
    dbl_diff = {1'b0, slot_i.r, 1'b0} - {2'b00, slot_i.div};
    if (!dbl_diff[fps_pkg::NUM_W+1]) begin
      mid_nxt.r = dbl_diff[fps_pkg::NUM_W-1:0];
      mid_nxt.q = {slot_i.q[fps_pkg::QACC_W-2:0], 1'b1};
    end else begin
      mid_nxt.r = {slot_i.r[fps_pkg::NUM_W-2:0], 1'b0};
      mid_nxt.q = {slot_i.q[fps_pkg::QACC_W-2:0], 1'b0};
    end
  end

  // Add half: when the multiplier bit is set, r + rem, reduced when it reaches div.
  always_comb begin
    out_nxt  = mid_r;
    add_sum  = {1'b0, mid_r.r} + {1'b0, mid_r.rem};
    add_diff = {1'b0, add_sum} - {2'b00, mid_r.div};
    if (mid_mbit_r) begin
      if (!add_diff[fps_pkg::NUM_W+1]) begin
        out_nxt.r = add_diff[fps_pkg::NUM_W-1:0];
        out_nxt.q = mid_r.q + {{(fps_pkg::QACC_W-1){1'b0}}, 1'b1};
      end else begin
        out_nxt.r = add_sum[fps_pkg::NUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      mid_valid_r <= valid_i;
      out_valid_r <= mid_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid_r      <= mid_nxt;
      mid_mbit_r <= mbit_i;
      out_r      <= out_nxt;
    end
  end

  assign valid_o = out_valid_r;
  assign slot_o  = out_r;

endmodule

`default_nettype wire

[design/fraction_product_scaler.sv]
// Top level: chain of step cells computing floor(numer_rem * scale / denom).
// Each cell registers its doubling half and then its remainder-add half.
// Throughput: one transaction per cycle; the whole chain holds while out_stall
// is high and a result is waiting, and in_stall follows that hold.
// Reset (synchronous, rst_n low) clears all stage valid bits; no data state.
`timescale 1ns / 1ps
`default_nettype none

module fraction_product_scaler (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [fps_pkg::NUM_W-1:0]    in_numer_rem,
  input  wire logic [fps_pkg::SCALE_W-1:0]  in_scale,
  input  wire logic [fps_pkg::NUM_W-1:0]    in_denom,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [fps_pkg::QUO_W-1:0]         out_quotient,
  output logic                              out_operand_error
);

  localparam int N = fps_pkg::SCALE_BITS;

  fps_pkg::fps_slot_t slot_s [N+1];
  logic [N:0]         valid_s;
  logic [N-1:0]       mbit_s;
  logic               adv;
  fps_pkg::fps_slot_t head_slot;
  fps_pkg::fps_slot_t last;

  // Advance unless a finished result is held by the consumer.
  assign adv      = !valid_s[N] || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    head_slot       = '0;
    head_slot.err   = !(in_numer_rem < in_denom);
    head_slot.rem   = in_numer_rem;
    head_slot.div   = in_denom;
    head_slot.scale = in_scale;
  end
  assign slot_s[0]  = head_slot;
  assign valid_s[0] = in_valid;

  for (genvar k = 0; k < N; k++) begin : g_cell
    localparam int BIT = N - 1 - k;
    if (BIT < fps_pkg::SCALE_W) begin : g_bit
      assign mbit_s[k] = slot_s[k].scale[BIT];
    end else begin : g_zero
      assign mbit_s[k] = 1'b0;
    end

    fps_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (valid_s[k]),
      .mbit_i  (mbit_s[k]),
      .slot_i  (slot_s[k]),
      .valid_o (valid_s[k+1]),
      .slot_o  (slot_s[k+1])
    );
  end

  assign last              = slot_s[N];
  assign out_valid         = valid_s[N];
  assign out_operand_error = last.err;

  if (fps_pkg::QACC_W >= fps_pkg::QUO_W) begin : g_qtrunc
    assign out_quotient = last.err ? '0 : last.q[fps_pkg::QUO_W-1:0];
  end else begin : g_qext
    assign out_quotient = last.err ? '0 :
        {{(fps_pkg::QUO_W-fps_pkg::QACC_W){1'b0}}, last.q};
  end

endmodule

`default_nettype wire
